/* rtl/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg: shared types and codes for the stack machine executor
// Opcodes, status codes, payload structs and controller/datapath links
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

  typedef enum logic [3:0] {
    OP_SWAP  = 4'd0,
    OP_POP   = 4'd1,
    OP_DUP   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_CMP   = 4'd7,
    OP_NEG   = 4'd8,
    OP_PUSH  = 4'd9,
    OP_READ  = 4'd10,
    OP_PRINT = 4'd11,
    OP_STOP  = 4'd12
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_HALT  = 3'd4
  } status_e;

  typedef struct packed {
    logic        [3:0]  cmd;
    logic signed [63:0] immediate;
    logic signed [63:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] print_value;
    logic               print_valid;
    logic        [2:0]  status;
    logic               halted_flag;
    logic        [6:0]  stack_depth;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_ITER,
    S_FIX,
    S_WRITE,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic rd_issue;  // start reads of top and second
    logic rd_top;    // capture top read data
    logic rd_sec;    // capture second read data
    logic it_start;  // initialise mul/div unit
    logic it_step;   // one mul/div step
    logic it_fix;    // sign fix of quotient
    logic wr_a;      // first stack write
    logic wr_b;      // second stack write (swap)
    logic commit;    // update pointer and halted, build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic it_done;
    logic is_muldiv;
    logic err;
    logic two_writes;
    logic any_write;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit: 64-bit stack machine instruction executor
//
//  channel | signals                       | role
//  in      | in_valid_i/in_ready_o/in_i    | one instruction per transaction
//  out     | out_valid_o/out_ready_i/out_o | one result per instruction
//
//  most instructions read, decide, write and commit before output hand-off; swap writes twice
//  mul and div also pass through the bit-serial mul/div unit
//  the single-port stack RAM serialises operand reads and result writes
//  one transaction in flight; in_ready_o low until its result is taken
//  asynchronous active-low reset clears pointer, halted state and sequencer state only
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sme_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sme_pkg::out_item_t  out_o
);
  import sme_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  sme_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (dp_cmd),
    .stat_o(dp_stat),
    .out_o (out_o)
  );

endmodule

`default_nettype wire

/* rtl/sme_ram.sv */
// ----------------------------------------------------------------------------
// sme_ram: generic single-port RAM
// One write or one read per cycle, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

/* rtl/sme_ctrl.sv */
// ----------------------------------------------------------------------------
// sme_ctrl: instruction sequencer
// Steps one transaction through read, execute, write and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sme_pkg::dp_stat_t stat_i,
  output sme_pkg::dp_cmd_t  cmd_o
);
  import sme_pkg::*;

  state_e state_q, state_d;
  logic   rd_phase_q, rd_phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_phase_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_phase_q <= rd_phase_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_phase_d  = rd_phase_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
          rd_phase_d = 1'b0;
        end
      end
      S_READ: begin
        // phase 0: address top, phase 1: capture top, address second
        cmd_o.rd_issue = 1'b1;
        if (!rd_phase_q) begin
          rd_phase_d = 1'b1;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.rd_sec = 1'b1;
        if (stat_i.err || !stat_i.any_write) begin
          state_d = S_OUT;
          cmd_o.commit = 1'b1;
        end else if (stat_i.is_muldiv) begin
          state_d = S_ITER;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_ITER: begin
        cmd_o.it_start = !rd_phase_q;
        cmd_o.it_step  = rd_phase_q;
        rd_phase_d     = 1'b1;
        if (rd_phase_q && stat_i.it_done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.it_fix = 1'b1;
        state_d      = S_WRITE;
        rd_phase_d   = 1'b0;
      end
      S_WRITE: begin
        if (stat_i.two_writes && !rd_phase_q) begin
          cmd_o.wr_b = 1'b1;
          rd_phase_d = 1'b1;
        end else begin
          cmd_o.wr_a   = 1'b1;
          cmd_o.commit = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_DECIDE && state_d == S_ITER) begin
      rd_phase_d = 1'b0;
    end
    if (state_q == S_DECIDE && state_d == S_WRITE) begin
      rd_phase_d = 1'b0;
    end
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output side active together");

  a_load_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_READ)
    else $error("accepted transaction not sequenced");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("commit without result");

endmodule

`default_nettype wire

/* rtl/sme_dp.sv */
// ----------------------------------------------------------------------------
// sme_dp: stack datapath
// Stack RAM, pointer, operand registers, ALU and shared mul/div unit
// ----------------------------------------------------------------------------
`default_nettype none

module sme_dp #(
  parameter int StackDepth = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sme_pkg::in_item_t   in_i,
  input  sme_pkg::dp_cmd_t    cmd_i,
  output sme_pkg::dp_stat_t   stat_o,
  output sme_pkg::out_item_t  out_o
);
  import sme_pkg::*;

  localparam int AW = $clog2(StackDepth);
  localparam int PW = $clog2(StackDepth + 1);

  in_item_t           in_q;
  logic [PW-1:0]      sp_q, sp_d;
  logic               halted_q;
  logic [63:0]        top_q, sec_q;
  out_item_t          out_q;

  // mul/div unit
  logic [63:0]        acc_q, opa_q, opb_q, rem_q;
  logic [6:0]         cnt_q;
  logic               neg_q;

  logic [AW-1:0]      addr;
  logic               we;
  logic [63:0]        wdata, rdata;

  sme_ram #(.Width(64), .Depth(StackDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  logic [1:0] need;
  logic grow, under, over, divz, err, muldiv, any_wr;
  logic [63:0] sec_v;
  logic [63:0] res;
  logic [PW-1:0] sp_m1, sp_m2;

  assign sp_m1  = sp_q - PW'(1);
  assign sp_m2  = sp_q - PW'(2);
  assign sec_v  = rdata;

  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    case (in_q.cmd)
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: need = 2'd2;
      OP_POP, OP_NEG, OP_PRINT:                        need = 2'd1;
      OP_DUP:  begin need = 2'd1; grow = 1'b1; end
      OP_PUSH, OP_READ: grow = 1'b1;
      default: ;
    endcase
  end

  assign under  = sp_q < PW'(need);
  assign over   = grow && (sp_q == PW'(StackDepth));
  assign divz   = (in_q.cmd == OP_DIV) && (top_q == 64'd0);
  assign err    = halted_q || under || over || divz;
  assign muldiv = (in_q.cmd == OP_MUL) || (in_q.cmd == OP_DIV);

  always_comb begin
    case (in_q.cmd)
      OP_SWAP, OP_DUP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_NEG,
      OP_PUSH, OP_READ: any_wr = 1'b1;
      default:          any_wr = 1'b0;
    endcase
  end

  assign stat_o.err        = err;
  assign stat_o.is_muldiv  = muldiv;
  assign stat_o.two_writes = (in_q.cmd == OP_SWAP);
  assign stat_o.it_done    = (cnt_q == 7'd63);
  assign stat_o.any_write  = any_wr;

  // result of the operation for the main write
  always_comb begin
    case (in_q.cmd)
      OP_ADD:  res = sec_q + top_q;
      OP_SUB:  res = sec_q - top_q;
      OP_MUL, OP_DIV: res = acc_q;
      OP_CMP: begin
        if ($signed(sec_q) > $signed(top_q))      res = 64'd1;
        else if ($signed(sec_q) < $signed(top_q)) res = '1;
        else                                       res = 64'd0;
      end
      OP_NEG:  res = 64'd0 - top_q;
      OP_DUP:  res = top_q;
      OP_PUSH: res = in_q.immediate;
      OP_READ: res = in_q.read_value;
      OP_SWAP: res = sec_q;
      default: res = top_q;
    endcase
  end

  // ram port: read top then second, then the swap write if any, then the main result write with commit
  always_comb begin
    we    = 1'b0;
    wdata = res;
    addr  = sp_m1[AW-1:0];
    if (cmd_i.rd_issue && cmd_i.rd_top) begin
      addr = sp_m2[AW-1:0];
    end
    if (cmd_i.wr_b) begin
      we    = 1'b1;
      wdata = top_q;
      addr  = sp_m2[AW-1:0];
    end else if (cmd_i.wr_a) begin
      we = 1'b1;
      case (in_q.cmd)
        OP_SWAP, OP_NEG:          addr = sp_m1[AW-1:0];
        OP_DUP, OP_PUSH, OP_READ: addr = sp_q[AW-1:0];
        default:                  addr = sp_m2[AW-1:0];
      endcase
    end
  end

  always_comb begin
    sp_d = sp_q;
    if (!err) begin
      case (in_q.cmd)
        OP_POP, OP_PRINT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: sp_d = sp_m1;
        OP_DUP, OP_PUSH, OP_READ: sp_d = sp_q + PW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      halted_q <= 1'b0;
    end else if (cmd_i.commit) begin
      sp_q <= sp_d;
      if (!err && in_q.cmd == OP_STOP) halted_q <= 1'b1;
    end
  end

  logic [64:0] trial;
  assign trial = {rem_q[63:0], opa_q[63]} - {1'b0, opb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
    if (cmd_i.rd_top) top_q <= rdata;
    if (cmd_i.rd_sec) sec_q <= sec_v;
    if (cmd_i.it_start) begin
      cnt_q <= '0;
      rem_q <= '0;
      if (in_q.cmd == OP_MUL) begin
        acc_q <= '0;
        opa_q <= sec_q;
        opb_q <= top_q;
        neg_q <= 1'b0;
      end else begin
        acc_q <= '0;
        opa_q <= sec_q[63] ? 64'd0 - sec_q : sec_q;
        opb_q <= top_q[63] ? 64'd0 - top_q : top_q;
        neg_q <= sec_q[63] ^ top_q[63];
      end
    end else if (cmd_i.it_step) begin
      cnt_q <= cnt_q + 7'd1;
      if (in_q.cmd == OP_MUL) begin
        // shift-add, one multiplier bit a step, msb first
        acc_q <= {acc_q[62:0], 1'b0} + (opa_q[63] ? opb_q : 64'd0);
        opa_q <= {opa_q[62:0], 1'b0};
      end else begin
        // restoring division, one quotient bit a step
        opa_q <= {opa_q[62:0], 1'b0};
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          acc_q <= {acc_q[62:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], opa_q[63]};
          acc_q <= {acc_q[62:0], 1'b0};
        end
      end
    end else if (cmd_i.it_fix) begin
      if (neg_q) acc_q <= 64'd0 - acc_q;
    end
    if (cmd_i.commit) begin
      out_q.print_valid <= !err && in_q.cmd == OP_PRINT;
      out_q.print_value <= (!err && in_q.cmd == OP_PRINT) ? top_q : 64'd0;
      if (halted_q)   out_q.status <= ST_HALT;
      else if (under) out_q.status <= ST_UNDER;
      else if (over)  out_q.status <= ST_OVER;
      else if (divz)  out_q.status <= ST_DIVZ;
      else            out_q.status <= ST_OK;
      out_q.halted_flag <= halted_q || (!err && in_q.cmd == OP_STOP);
      out_q.stack_depth <= 7'(sp_d);
    end
  end

  assign out_o = out_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(StackDepth))
    else $error("stack pointer beyond depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted cleared");

  a_no_write_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !err)
    else $error("stack written on error");

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stack machine executor
// Drives instruction transactions with random gaps, predicts each result from
// a local copy of the data stack and compares every output transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sme_pkg::*;

  localparam int DEPTH = 64;
  localparam int WD_LIMIT = 20000;
  localparam int N_RAND = 2000;

  class stack_scoreboard;
    logic [63:0] stk [DEPTH];
    int          sp;
    bit          halted;
    out_item_t   pending [$];
    int          mismatches;

    function new();
      sp = 0;
      halted = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] quot(logic [63:0] n, logic [63:0] d);
      logic [63:0] mn;
      logic [63:0] md;
      logic [63:0] q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] ^ d[63]) ? -q : q;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int need;
      bit grow;
      logic [63:0] t;
      logic [63:0] s;
      r = '0;
      need = 0;
      grow = 0;
      t = 0;
      s = 0;
      if (halted) begin
        r.status = ST_HALT;
      end else begin
        case (it.cmd)
          OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: need = 2;
          OP_POP, OP_NEG, OP_PRINT: need = 1;
          OP_DUP: begin
            need = 1;
            grow = 1;
          end
          OP_PUSH, OP_READ: grow = 1;
          default: ;
        endcase
        if (sp >= 1) t = stk[sp-1];
        if (sp >= 2) s = stk[sp-2];
        if (sp < need) r.status = ST_UNDER;
        else if (grow && sp >= DEPTH) r.status = ST_OVER;
        else if (it.cmd == OP_DIV && t == 0) r.status = ST_DIVZ;
        else begin
          r.status = ST_OK;
          case (it.cmd)
            OP_SWAP: begin
              stk[sp-1] = s;
              stk[sp-2] = t;
            end
            OP_POP: sp--;
            OP_DUP: begin
              stk[sp] = t;
              sp++;
            end
            OP_ADD: begin
              stk[sp-2] = s + t;
              sp--;
            end
            OP_SUB: begin
              stk[sp-2] = s - t;
              sp--;
            end
            OP_MUL: begin
              stk[sp-2] = s * t;
              sp--;
            end
            OP_DIV: begin
              stk[sp-2] = quot(s, t);
              sp--;
            end
            OP_CMP: begin
              stk[sp-2] = ($signed(s) > $signed(t)) ? 64'd1 :
                          ($signed(s) < $signed(t)) ? '1 : 64'd0;
              sp--;
            end
            OP_NEG: stk[sp-1] = -t;
            OP_PUSH: begin
              stk[sp] = it.immediate;
              sp++;
            end
            OP_READ: begin
              stk[sp] = it.read_value;
              sp++;
            end
            OP_PRINT: begin
              r.print_value = t;
              r.print_valid = 1;
              sp--;
            end
            OP_STOP: halted = 1;
            default: ;
          endcase
        end
      end
      r.halted_flag = halted;
      r.stack_depth = 7'(sp);
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  out_item_t out_o;

  stack_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_rx = 0;
  bit  tx_done = 0;

  stack_machine_executor_unit #(.STACK_DEPTH(DEPTH)) u_top (.*);

  always #10 clk_i = ~clk_i;

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [63:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return 0;
      4: return 64'($urandom_range(0, 20)) - 64'd10;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(logic [3:0] cmd, logic [63:0] imm, logic [63:0] rd);
    in_i.cmd <= cmd;
    in_i.immediate <= imm;
    in_i.read_value <= rd;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(in_i);
    @(negedge clk_i);
    in_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic send_gap(logic [3:0] cmd, logic [63:0] imm, logic [63:0] rd);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    send(cmd, imm, rd);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // mostly well-formed sequences biased to keep the stack in range
  task automatic rand_item();
    int p;
    logic [3:0] c;
    p = $urandom_range(0, 99);
    if (sb.sp < 3 && p < 50) c = OP_PUSH;
    else if (sb.sp > 55 && p < 50) c = 4'($urandom_range(3, 7));
    else if (p < 3) c = 4'($urandom_range(13, 15));
    else c = 4'($urandom_range(0, 11));
    send_gap(c, rand_val(), rand_val());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    // underflow on empty stack for swap, pop, print and add, then edge-value arithmetic
    send(OP_SWAP, 0, 0);
    send(OP_POP, 0, 0);
    send(OP_PRINT, 0, 0);
    send(OP_ADD, 0, 0);
    send(OP_PUSH, 64'h8000_0000_0000_0000, 0);
    send(OP_READ, 0, '1);
    send(OP_DIV, 0, 0);
    send(OP_PUSH, 0, 0);
    send(OP_PUSH, '1, 0);
    send(OP_DIV, 0, 0);
    send(OP_NEG, 0, 0);
    send(OP_CMP, 0, 0);
    send(OP_DUP, 0, 0);
    send(OP_MUL, 0, 0);
    send(4'd13, 0, 0);
    send(4'd15, 0, 0);
    send(OP_PUSH, 64'h7fff_ffff_ffff_ffff, 0);
    send(OP_SUB, 0, 0);
    send(OP_PRINT, 0, 0);
    // fill to overflow, starting with the receiver holding off
    hold_rx = 1;
    while (sb.sp < DEPTH) send(OP_READ, 0, rand_val());
    send(OP_PUSH, 1, 0);
    send(OP_DUP, 0, 0);
    drain();
    while (sb.sp > 0) send_gap(OP_PRINT, 0, 0);
    repeat (N_RAND) rand_item();
    drain();
    send(OP_STOP, 0, 0);
    send(OP_PUSH, 5, 0);
    send(OP_PRINT, 0, 0);
    tx_done = 1;
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 0;
        repeat (200) @(negedge clk_i);
        hold_rx = 0;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        if (g > 0) begin
          out_ready_i <= 0;
          repeat (g - 1) @(negedge clk_i);
        end else out_ready_i <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles > WD_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else if (tx_done && sb.pending.size() == 0) begin
        repeat (200) @(posedge clk_i);
        if (sb.mismatches == 0 && sb.pending.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

/* files.f */
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/sme_ctrl.sv
rtl/sme_dp.sv
rtl/stack_machine_executor_unit.sv
tb/tb.sv
